### rtl/kmp_pkg.sv
package kmp_pkg;

    // default sizes, handed to the top-level parameters
    localparam int unsigned PAT_MAX_DEF  = 256;
    localparam int unsigned TEXT_MAX_DEF = 65536;

    // fixed payload widths
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned POS_W  = 16;

    // request kinds
    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_TEXT    = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_PAT       = 4'd2,
        OP_TXT_OPEN  = 4'd3,
        OP_TXT_DONE  = 4'd4,
        OP_TXT_EMPTY = 4'd5,
        OP_M_START   = 4'd6,
        OP_M_STEP    = 4'd7,
        OP_B_STEP    = 4'd8,
        OP_B_WR      = 4'd9,
        OP_OUT       = 4'd10
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_text;
        logic is_last;
        logic pat_open;
        logic srch_done;
        logic len_zero;
        logic b_adv;
        logic b_end;
        logic m_follow;
        logic m_emit;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/kmp_if.sv
interface kmp_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [kmp_pkg::CHAR_W-1:0] char_byte;
    logic                       last;

    modport source (output valid, output req_type, output char_byte, output last,
                    input ready);
    modport sink   (input valid, input req_type, input char_byte, input last,
                    output ready);
endinterface

interface kmp_res_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [kmp_pkg::POS_W-1:0] match_pos;

    modport source (output valid, output found, output match_pos, input ready);
    modport sink   (input valid, input found, input match_pos, output ready);
endinterface

### rtl/kmp_first_match_search.sv
// Knuth-Morris-Pratt first-match search. Send pattern bytes (req_type 0) and
// mark the final one with last; that byte starts the failure-table build.
// Then send text bytes (req_type 1), last on the final byte of each text.
// Each text gives one result: found with the zero-based start of the first
// occurrence, on the byte that completes it, or not found on the last byte.
// Every request passes an accept state and a decode state. A text byte that
// reaches the matcher adds a memory-read state and a compare state per
// comparison; over a text, failure-chain steps amortize to one per byte.
// A byte with a result then passes an output state that loads the output
// register once it is free; the register holds the result while the next
// request is taken.
// Closing a pattern runs the table build, which reads the failure-link memory
// through its single read port; no request is taken meanwhile. Memories need
// no clearing after reset.
module kmp_first_match_search #(
    parameter int unsigned PAT_MAX  = kmp_pkg::PAT_MAX_DEF,
    parameter int unsigned TEXT_MAX = kmp_pkg::TEXT_MAX_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    kmp_req_if.sink   i_req,
    kmp_res_if.source o_res
);

    // command and status between sequencer and datapath
    kmp_pkg::t_dp_cmd  w_cmd;
    kmp_pkg::t_dp_stat w_stat;
    logic              w_in_ready;

    // sequencer: takes a request only when idle
    kmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_req.ready = w_in_ready;

    // datapath: pattern store, failure links, match counters, output register
    kmp_dp #(
        .PAT_MAX  (PAT_MAX),
        .TEXT_MAX (TEXT_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req_type  (i_req.req_type),
        .i_char_byte (i_req.char_byte),
        .i_last      (i_req.last),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_found     (o_res.found),
        .o_match_pos (o_res.match_pos)
    );

endmodule

### rtl/kmp_ctrl.sv
module kmp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kmp_pkg::t_dp_stat i_stat,
    output kmp_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_B_RD   = 9'b000000100,
        S_B_CMP  = 9'b000001000,
        S_B_RD2  = 9'b000010000,
        S_B_WR   = 9'b000100000,
        S_M_RD   = 9'b001000000,
        S_M_CMP  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = kmp_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = kmp_pkg::OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.is_text) begin
                    o_cmd.op = kmp_pkg::OP_PAT;
                    n_state  = i_stat.is_last ? S_B_RD : S_IDLE;
                end else if (i_stat.pat_open) begin
                    o_cmd.op = kmp_pkg::OP_TXT_OPEN;
                    n_state  = i_stat.is_last ? S_OUT : S_IDLE;
                end else if (i_stat.srch_done) begin
                    o_cmd.op = kmp_pkg::OP_TXT_DONE;
                    n_state  = S_IDLE;
                end else if (i_stat.len_zero) begin
                    o_cmd.op = kmp_pkg::OP_TXT_EMPTY;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = kmp_pkg::OP_M_START;
                    n_state  = S_M_RD;
                end
            end
            S_B_RD: begin
                n_state = S_B_CMP;
            end
            S_B_CMP: begin
                o_cmd.op = kmp_pkg::OP_B_STEP;
                if (!i_stat.b_adv) begin
                    n_state = S_B_RD;
                end else if (i_stat.b_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_B_RD2;
                end
            end
            S_B_RD2: begin
                n_state = S_B_WR;
            end
            S_B_WR: begin
                o_cmd.op = kmp_pkg::OP_B_WR;
                n_state  = S_B_CMP;
            end
            S_M_RD: begin
                n_state = S_M_CMP;
            end
            S_M_CMP: begin
                o_cmd.op = kmp_pkg::OP_M_STEP;
                if (i_stat.m_follow) begin
                    n_state = S_M_RD;
                end else if (i_stat.m_emit) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = kmp_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/kmp_dp.sv
module kmp_dp #(
    parameter int unsigned PAT_MAX  = kmp_pkg::PAT_MAX_DEF,
    parameter int unsigned TEXT_MAX = kmp_pkg::TEXT_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kmp_pkg::t_dp_cmd           i_cmd,
    output kmp_pkg::t_dp_stat          o_stat,
    input  logic                       i_req_type,
    input  logic [kmp_pkg::CHAR_W-1:0] i_char_byte,
    input  logic                       i_last,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_found,
    output logic [kmp_pkg::POS_W-1:0]  o_match_pos
);

    localparam int unsigned PW = $clog2(PAT_MAX);
    localparam int unsigned LW = $clog2(PAT_MAX + 1);
    localparam int unsigned KW = PW + 1;
    localparam int unsigned TW = $clog2(TEXT_MAX);
    localparam int unsigned EW = ((TW > LW) ? TW : LW) + 1;
    localparam int unsigned CW = kmp_pkg::CHAR_W;
    localparam int unsigned QW = kmp_pkg::POS_W;

    // pattern bytes and failure links (msb set means restart past the byte)
    logic [CW-1:0] mem_pat  [PAT_MAX];
    logic [KW-1:0] mem_fail [PAT_MAX];

    logic          r_type;
    logic [CW-1:0] r_char;
    logic          r_last;

    logic [LW-1:0] r_len;
    logic          r_open;
    logic [PW-1:0] r_matched;
    logic [TW-1:0] r_text_pos;
    logic          r_done;

    logic [PW-1:0] r_i;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_pa;
    logic [CW-1:0] r_pb;
    logic [KW-1:0] r_fk;

    logic          r_res_found;
    logic [QW-1:0] r_res_pos;
    logic          r_out_valid;
    logic          r_found;
    logic [QW-1:0] r_pos;

    logic [LW-1:0]    eff_len;
    logic             pat_room;
    logic             pat_we;
    logic             fail_we;
    logic [PW-1:0]    fail_waddr;
    logic [KW-1:0]    fail_wdata;
    logic             b_adv;
    logic             b_end;
    logic             m_eq;
    logic             m_follow;
    logic [LW-1:0]    m_kn;
    logic             m_hit;
    logic [KW-1:0]    m_start_k;
    logic             text_sat;
    logic [EW-1:0]    pos_end;
    logic [EW-1:0]    pos_len;
    logic [EW-1:0]    pos_val;
    logic [EW+QW-1:0] pos_ext;
    logic             out_free;

    always_comb begin
        eff_len  = r_open ? r_len : '0;
        pat_room = eff_len < LW'(PAT_MAX);
        pat_we   = (i_cmd.op == kmp_pkg::OP_PAT) && pat_room;

        fail_we    = 1'b0;
        fail_waddr = r_i;
        fail_wdata = (r_pa == r_pb) ? r_fk : r_k;
        if ((i_cmd.op == kmp_pkg::OP_PAT) && r_last) begin
            fail_we    = 1'b1;
            fail_waddr = '0;
            fail_wdata = '1;
        end else if (i_cmd.op == kmp_pkg::OP_B_WR) begin
            fail_we = 1'b1;
        end

        b_adv = r_k[KW-1] || (r_pa == r_pb);
        b_end = (LW'(r_i) + LW'(1)) == r_len;

        m_eq     = r_pb == r_char;
        m_follow = !m_eq && !r_fk[KW-1];
        m_kn     = m_eq ? (LW'(r_k[PW-1:0]) + LW'(1)) : '0;
        m_hit    = m_kn == r_len;

        m_start_k = (LW'(r_matched) < r_len) ? {1'b0, r_matched} : '0;
        text_sat  = r_text_pos == TW'(TEXT_MAX - 1);

        // start = end of match + 1 - length, clamped at zero
        pos_end = EW'(r_text_pos) + EW'(1);
        pos_len = EW'(r_len);
        pos_val = (pos_end >= pos_len) ? (pos_end - pos_len) : '0;
        pos_ext = {{QW{1'b0}}, pos_val};

        out_free = !r_out_valid || i_out_ready;
    end

    assign o_stat.is_text   = r_type == kmp_pkg::REQ_TEXT;
    assign o_stat.is_last   = r_last;
    assign o_stat.pat_open  = r_open;
    assign o_stat.srch_done = r_done;
    assign o_stat.len_zero  = r_len == '0;
    assign o_stat.b_adv     = b_adv;
    assign o_stat.b_end     = b_end;
    assign o_stat.m_follow  = m_follow;
    assign o_stat.m_emit    = m_hit || r_last;
    assign o_stat.out_free  = out_free;

    // memories: one write port, registered reads
    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            mem_pat[eff_len[PW-1:0]] <= r_char;
        end
        r_pa <= mem_pat[r_i];
        r_pb <= mem_pat[r_k[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (fail_we) begin
            mem_fail[fail_waddr] <= fail_wdata;
        end
        r_fk <= mem_fail[r_k[PW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_open      <= 1'b0;
            r_matched   <= '0;
            r_text_pos  <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op) inside
                kmp_pkg::OP_PAT: begin
                    r_open <= !r_last;
                    r_len  <= pat_room ? (eff_len + LW'(1)) : eff_len;
                    if (r_last) begin
                        r_matched  <= '0;
                        r_text_pos <= '0;
                        r_done     <= 1'b0;
                    end
                end
                kmp_pkg::OP_TXT_OPEN, kmp_pkg::OP_TXT_DONE: begin
                    if (r_last) begin
                        r_matched  <= '0;
                        r_text_pos <= '0;
                        r_done     <= 1'b0;
                    end
                end
                kmp_pkg::OP_TXT_EMPTY: begin
                    if (r_last) begin
                        r_matched  <= '0;
                        r_text_pos <= '0;
                        r_done     <= 1'b0;
                    end else begin
                        r_done <= 1'b1;
                    end
                end
                kmp_pkg::OP_M_STEP: begin
                    if (!m_follow) begin
                        if (r_last) begin
                            r_matched  <= '0;
                            r_text_pos <= '0;
                            r_done     <= 1'b0;
                        end else if (m_hit) begin
                            r_done <= 1'b1;
                        end else begin
                            r_matched <= m_kn[PW-1:0];
                            if (!text_sat) begin
                                r_text_pos <= r_text_pos + TW'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (i_cmd.op == kmp_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op) inside
            kmp_pkg::OP_LOAD: begin
                r_type <= i_req_type;
                r_char <= i_char_byte;
                r_last <= i_last;
            end
            kmp_pkg::OP_PAT: begin
                if (r_last) begin
                    r_i <= '0;
                    r_k <= '1;
                end
            end
            kmp_pkg::OP_TXT_OPEN: begin
                r_res_found <= 1'b0;
                r_res_pos   <= '0;
            end
            kmp_pkg::OP_TXT_EMPTY: begin
                r_res_found <= 1'b1;
                r_res_pos   <= '0;
            end
            kmp_pkg::OP_M_START: begin
                r_k <= m_start_k;
            end
            kmp_pkg::OP_M_STEP: begin
                if (m_follow) begin
                    r_k <= r_fk;
                end else begin
                    r_res_found <= m_hit;
                    r_res_pos   <= m_hit ? pos_ext[QW-1:0] : '0;
                end
            end
            kmp_pkg::OP_B_STEP: begin
                if (b_adv) begin
                    r_i <= r_i + PW'(1);
                    r_k <= r_k + KW'(1);
                end else begin
                    r_k <= r_fk;
                end
            end
            kmp_pkg::OP_OUT: begin
                r_found <= r_res_found;
                r_pos   <= r_res_pos;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_match_pos = r_pos;

endmodule
